### src/dsn_pkg.sv
// Shared types and constants for the discount smoothing normaliser.
`timescale 1ns / 1ps
package dsn_pkg;
  localparam int MaxLenDefault = 64;
  localparam logic [31:0] OneQ31 = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] count;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] prob;
    logic [5:0]  index;
    logic        final_res;
    logic        below_discount;
    logic        empty_total;
  } out_item_t;

  // Vector summary handed from the front end to the back end.
  typedef struct packed {
    logic [6:0]  len;
    logic [39:0] total;
    logic [39:0] disc;
    logic        warn;
  } vec_job_t;
endpackage

### src/dsn_front.sv
// Front end: takes counts, discounts and stores them, builds the sums.
`timescale 1ns / 1ps
module dsn_front #(
  parameter int MAX_LEN = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        discount,
  input  logic               in_valid,
  output logic               in_stall,
  input  dsn_pkg::in_item_t  in_data,
  output logic               job_valid,
  input  logic               job_ready,
  output dsn_pkg::vec_job_t  job,
  output logic               bank_sel,
  // store write port
  output logic               wr_en,
  output logic               wr_bank,
  output logic [5:0]         wr_addr,
  output logic [31:0]        wr_data
);
  import dsn_pkg::*;

  logic [39:0] total_r, disc_r;
  logic [6:0]  fill_r;
  logic        warn_r, bank_r;
  logic        job_valid_r;
  vec_job_t    job_r;
  logic        acc, ends, pos;
  logic [6:0]  fill_nxt;

  // Front stalls while a finished vector still waits for the back end.
  assign in_stall = job_valid_r;
  assign acc      = in_valid && !in_stall;
  assign pos      = in_data.count != 32'd0;
  assign fill_nxt = fill_r + 7'd1;
  assign ends     = in_data.last || (fill_nxt >= 7'(MAX_LEN));

  assign wr_en   = acc;
  assign wr_bank = bank_r;
  assign wr_addr = fill_r[5:0];
  always_comb begin
    if (pos && in_data.count >= discount) wr_data = in_data.count - discount;
    else wr_data = in_data.count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0; disc_r <= '0; fill_r <= '0; warn_r <= 1'b0;
      bank_r <= 1'b0; job_valid_r <= 1'b0;
    end else begin
      if (job_valid_r && job_ready) begin
        job_valid_r <= 1'b0;
        bank_r      <= !bank_r;
      end
      if (acc) begin
        if (ends) begin
          job_valid_r <= 1'b1;
          job_r.len   <= fill_nxt;
          job_r.total <= total_r + (pos ? 40'(in_data.count) : 40'd0);
          job_r.disc  <= disc_r + ((pos && in_data.count >= discount) ? 40'(discount) : 40'd0);
          job_r.warn  <= warn_r || (pos && in_data.count < discount);
          total_r <= '0; disc_r <= '0; fill_r <= '0; warn_r <= 1'b0;
        end else begin
          fill_r <= fill_nxt;
          if (pos) total_r <= total_r + 40'(in_data.count);
          if (pos && in_data.count >= discount) disc_r <= disc_r + 40'(discount);
          if (pos && in_data.count < discount) warn_r <= 1'b1;
        end
      end
    end
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;
  assign bank_sel  = bank_r;

  always_ff @(posedge clk) begin
    if (rst_n) begin
      assert (!(job_valid_r && in_stall == 1'b0)) else $error("front open with job pending");
    end
  end
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < 7'(MAX_LEN)) else $error("fill overrun");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    acc && ends |=> fill_r == 7'd0) else $error("fill not cleared");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r && !job_ready |=> $stable(job_r)) else $error("job changed");
endmodule

### src/dsn_back.sv
// Back end: divides each stored count by the vector denominator and emits results.
`timescale 1ns / 1ps
module dsn_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  dsn_pkg::vec_job_t  job,
  output logic [5:0]         rd_addr,
  input  logic [31:0]        rd_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dsn_pkg::out_item_t out_data
);
  import dsn_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_DEN = 3'd1, S_READ = 3'd2, S_NUM = 3'd3,
                         S_DIV = 3'd4, S_OUT = 3'd5;

  logic [2:0]  state_r;
  vec_job_t    job_r;
  logic [46:0] den_r;
  logic [46:0] rem_r;
  logic [31:0] q_r;
  logic [4:0]  bit_r;
  logic [5:0]  k_r;
  logic        empty_r;
  out_item_t   out_r;
  logic        out_valid_r;
  logic [47:0] rem_sh;
  logic [47:0] num_w;
  logic        out_fire;

  assign job_ready = state_r == S_IDLE;
  assign rd_addr   = k_r;
  assign rem_sh    = {rem_r, 1'b0};
  // count*len fits 38 bits, plus disc gives at most 39 bits
  assign num_w = 48'(rd_data) * 48'(job_r.len) + 48'(job_r.disc);
  assign out_fire = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid_r <= 1'b0;
    end else begin
      if (out_fire) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (job_valid) begin
          job_r   <= job;
          empty_r <= job.total == 40'd0;
          k_r     <= '0;
          state_r <= S_DEN;
        end
        S_DEN: begin
          den_r   <= 47'(job_r.total * 47'(job_r.len));
          state_r <= S_READ;
        end
        S_READ: state_r <= S_NUM;
        S_NUM: begin
          bit_r <= '0;
          if (empty_r) begin
            q_r <= '0; state_r <= S_OUT;
          end else if (num_w >= 48'(den_r)) begin
            q_r <= OneQ31; state_r <= S_OUT;
          end else begin
            q_r <= '0; rem_r <= num_w[46:0]; state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_sh >= 48'(den_r)) begin
            rem_r <= 47'(rem_sh - 48'(den_r)); q_r <= {q_r[30:0], 1'b1};
          end else begin
            rem_r <= rem_sh[46:0]; q_r <= {q_r[30:0], 1'b0};
          end
          bit_r <= bit_r + 5'd1;
          if (bit_r == 5'd30) state_r <= S_OUT;
        end
        S_OUT: if (out_fire) begin
          out_r.prob <= q_r;
          out_r.index <= k_r;
          out_r.final_res <= 7'(k_r) + 7'd1 == job_r.len;
          out_r.below_discount <= job_r.warn;
          out_r.empty_total <= empty_r;
          if (7'(k_r) + 7'd1 == job_r.len) state_r <= S_IDLE;
          else begin
            k_r <= k_r + 6'd1; state_r <= S_READ;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.prob <= OneQ31) else $error("prob above one");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.empty_total |-> out_r.prob == 32'd0) else $error("empty nonzero");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_r)) else $error("beat dropped");
endmodule

### src/dsn_store.sv
// Two-bank count store: front writes one bank while the back end reads the other.
`timescale 1ns / 1ps
module dsn_store #(
  parameter int MAX_LEN = 64
) (
  input  logic        clk,
  input  logic        wr_en,
  input  logic        wr_bank,
  input  logic [5:0]  wr_addr,
  input  logic [31:0] wr_data,
  input  logic        rd_bank,
  input  logic [5:0]  rd_addr,
  output logic [31:0] rd_data
);
  localparam int Depth = 2 * MAX_LEN;
  localparam int Aw = $clog2(Depth);
  logic [31:0] mem [Depth];
  logic [31:0] rd_r;
  logic [Aw-1:0] wa, ra;

  // bank one sits MAX_LEN entries above bank zero
  assign wa = wr_bank ? Aw'(wr_addr) + Aw'(MAX_LEN) : Aw'(wr_addr);
  assign ra = rd_bank ? Aw'(rd_addr) + Aw'(MAX_LEN) : Aw'(rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wa] <= wr_data;
    rd_r <= mem[ra];
  end
  assign rd_data = rd_r;
endmodule

### src/discount_smooth_normalize_top.sv
// Top level of the discount smoothing normaliser.
//  channel | dir | handshake       | beat
//  in_     | in  | valid / stall   | in_item_t (count, last)
//  out_    | out | valid / stall   | out_item_t (prob, index, flags)
//  cfg_    | in  | valid / ready   | 32-bit discount
// Counts are taken one a cycle while in_stall is low, into one bank of the
// store; a full vector is then handed to the back end, which divides each
// element with a 31-step restoring divider and can be held by result stalls.
// The front takes the next vector into the other bank meanwhile, stalling while
// a finished vector waits for the back end. Reset is synchronous, active low.
`timescale 1ns / 1ps
module discount_smooth_normalize_top #(
  parameter int MAX_LEN = dsn_pkg::MaxLenDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dsn_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dsn_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  import dsn_pkg::*;

  logic [31:0] discount_r;
  logic        job_valid, job_ready, bank_sel;
  vec_job_t    job;
  logic        wr_en, wr_bank;
  logic [5:0]  wr_addr, rd_addr;
  logic [31:0] wr_data, rd_data;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) discount_r <= '0;
    else if (cfg_valid) discount_r <= cfg_data;
  end

  dsn_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk, .rst_n, .discount(discount_r), .in_valid, .in_stall, .in_data,
    .job_valid, .job_ready, .job, .bank_sel, .wr_en, .wr_bank, .wr_addr, .wr_data
  );

  dsn_store #(.MAX_LEN(MAX_LEN)) u_store (
    .clk, .wr_en, .wr_bank, .wr_addr, .wr_data,
    .rd_bank(!bank_sel), .rd_addr, .rd_data
  );

  dsn_back u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job, .rd_addr, .rd_data,
    .out_valid, .out_stall, .out_data
  );
endmodule

### dv/dsn_checker.sv
// Scoreboard for the discount smoothing normaliser: predicts each vector and checks every result beat.
`timescale 1ns / 1ps
module dsn_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  dsn_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  dsn_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  output int                 mismatches,
  output int                 pending
);
  import dsn_pkg::*;

  localparam int VecMax = MaxLenDefault;

  logic [31:0] discount_q;
  logic [31:0] stored_cnt [VecMax];
  logic [39:0] total_q;
  logic [39:0] disc_mass_q;
  logic [6:0]  fill_q;
  logic        warn_q;
  out_item_t   prob_fifo [$];

  assign pending = prob_fifo.size();

  // floor(num * 2^31 / den), clipped at one
  function automatic logic [31:0] q31_ratio(logic [63:0] num, logic [63:0] den);
    logic [127:0] wide;
    if (num >= den) return OneQ31;
    wide = {64'd0, num} << 31;
    wide = wide / {64'd0, den};
    return wide[31:0];
  endfunction

  task automatic absorb_count(in_item_t beat);
    logic [5:0]  pos;
    logic [6:0]  len;
    logic [63:0] den;
    logic [63:0] num;
    out_item_t   res;
    pos = fill_q[5:0];
    if (beat.count != 0 && beat.count >= discount_q) begin
      total_q         = total_q + beat.count;
      disc_mass_q     = disc_mass_q + discount_q;
      stored_cnt[pos] = beat.count - discount_q;
    end else if (beat.count != 0) begin
      total_q         = total_q + beat.count;
      warn_q          = 1'b1;
      stored_cnt[pos] = beat.count;
    end else begin
      stored_cnt[pos] = '0;
    end
    fill_q = {1'b0, pos} + 7'd1;
    if (!beat.last && fill_q < VecMax) return;
    len = fill_q;
    den = 64'(total_q) * len;
    for (int k = 0; k < len; k++) begin
      num = 64'(stored_cnt[k]) * len + disc_mass_q;
      res.prob           = (total_q == 0) ? '0 : q31_ratio(num, den);
      res.index          = k[5:0];
      res.final_res      = (k + 1 == len);
      res.below_discount = warn_q;
      res.empty_total    = (total_q == 0);
      prob_fifo.push_back(res);
    end
    total_q     = '0;
    disc_mass_q = '0;
    fill_q      = '0;
    warn_q      = 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      discount_q  = '0;
      total_q     = '0;
      disc_mass_q = '0;
      fill_q      = '0;
      warn_q      = 1'b0;
      prob_fifo.delete();
      mismatches  = 0;
    end else begin
      if (cfg_valid && cfg_ready) discount_q = cfg_data;
      if (in_valid && !in_stall) absorb_count(in_data);
      if (out_valid && !out_stall) begin
        if (prob_fifo.size() == 0) begin
          $error("result beat with nothing expected: %0h", out_data);
          mismatches++;
        end else begin
          want = prob_fifo.pop_front();
          check_field("prob", want.prob, out_data.prob);
          check_field("index", want.index, out_data.index);
          check_field("final_res", want.final_res, out_data.final_res);
          check_field("below_discount", want.below_discount, out_data.below_discount);
          check_field("empty_total", want.empty_total, out_data.empty_total);
        end
      end
    end
  end
endmodule

### dv/discount_smooth_normalize_top_tb.sv
// Testbench top for the discount smoothing normaliser: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module discount_smooth_normalize_top_tb;
  import dsn_pkg::*;

  localparam int CycleLimit = 600000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b1;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [31:0] cfg_data = '0;

  int          mismatches;
  int          pending;
  int          cycles = 0;
  int          counts_sent = 0;
  logic [31:0] cur_discount = '0;
  bit          no_gaps = 0;
  bit          hold_go = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  discount_smooth_normalize_top u_top (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  dsn_checker u_chk (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_data,
    .mismatches, .pending
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stall pattern, plus one long hold-off so both banks fill
  initial begin
    int r;
    repeat (12) @(posedge clk);
    forever begin
      if (hold_go) begin
        hold_go = 0;
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else if (r < 92) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 50)) @(posedge clk);
      end
    end
  end

  task automatic send_count(logic [31:0] cnt, logic lst);
    int gap;
    gap = 0;
    if (!no_gaps && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{count: cnt, last: lst};
    do @(posedge clk); while (in_stall);
    counts_sent++;
  endtask

  task automatic write_discount(logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_discount = val;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return cur_discount;
      2: return (cur_discount > 1) ? $urandom_range(1, cur_discount - 1) : 32'd1;
      3: return cur_discount + 32'd1;
      4: return 32'hFFFF_FFFF;
      5: return $urandom_range(0, 1023);
      default: return $urandom;
    endcase
  endfunction

  // len counts beats; with no_last the final beat is sent unmarked
  task automatic send_vector(int len, bit no_last);
    for (int i = 0; i < len; i++)
      send_count(pick_count(), (i == len - 1) && !no_last);
  endtask

  initial begin
    logic [31:0] disc_plan [8];
    int          len;
    int          r;
    disc_plan = '{32'd0, 32'hFFFF_FFFF, 32'h0000_0100, 32'h0000_0040,
                  32'h0001_0000, 32'h0000_0001, 32'h0, 32'h0000_3000};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // plain normalisation, zero total, extreme counts
    write_discount(32'd0);
    send_count(32'd0, 1'b1);
    send_count(32'd0, 1'b0);
    send_count(32'd0, 1'b1);
    send_count(32'hFFFF_FFFF, 1'b0);
    send_count(32'd0, 1'b0);
    send_count(32'd1, 1'b1);
    send_count(32'hFFFF_FFFF, 1'b1);
    drain();
    // count equal to, below and above the discount
    write_discount(32'h0000_0100);
    send_count(32'h0000_0100, 1'b0);
    send_count(32'h0000_0050, 1'b0);
    send_count(32'h0000_0300, 1'b0);
    send_count(32'd0, 1'b1);
    send_count(32'h0000_0100, 1'b1);
    send_count(32'h0000_00FF, 1'b1);
    drain();
    // discount at its maximum: all counts below, or equal
    write_discount(32'hFFFF_FFFF);
    send_count(32'hFFFF_FFFF, 1'b0);
    send_count(32'h1234_5678, 1'b1);
    send_count(32'hFFFF_FFFF, 1'b1);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_discount((p == 3 || p == 6) ? $urandom : disc_plan[p]);
      if (p == 1) hold_go = 1;
      while (counts_sent < 55 * (p + 1)) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 85)      len = $urandom_range(1, 8);
        else if (r < 95) len = $urandom_range(9, 40);
        else             len = ($urandom_range(0, 1) == 0) ? 64 : 70;
        send_vector(len, (len == 64) && $urandom_range(0, 1));
      end
      // close any vector still left open in the checker
      if (pending == 0 && u_chk.fill_q != 0) send_count(pick_count(), 1'b1);
      no_gaps = 0;
      drain();
    end

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

### sim.f
src/dsn_pkg.sv
src/dsn_front.sv
src/dsn_back.sv
src/dsn_store.sv
src/discount_smooth_normalize_top.sv
dv/dsn_checker.sv
dv/discount_smooth_normalize_top_tb.sv
